/* rtl/irpdt_pkg.sv */
// shared types, constants and helpers for the ir pulse-distance transmitter
// no dependencies
package irpdt_pkg;

  localparam int unsigned DataBits = 8;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 14;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned BitsW    = $clog2(DataBits + 1);

  typedef logic [LenW-1:0]     len_t;
  typedef logic [DataBits-1:0] word_t;
  typedef logic [BitsW-1:0]    bits_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HDR_MARK  = 3'd0,
    REG_HDR_SPACE = 3'd1,
    REG_BIT_MARK  = 3'd2,
    REG_ZERO_SP   = 3'd3,
    REG_ONE_SP    = 3'd4,
    REG_STOP_MARK = 3'd5
  } cfg_idx_e;

  localparam len_t HdrMarkRst  = len_t'(9000);
  localparam len_t HdrSpaceRst = len_t'(4500);
  localparam len_t BitMarkRst  = len_t'(560);
  localparam len_t ZeroSpRst   = len_t'(560);
  localparam len_t OneSpRst    = len_t'(1700);
  localparam len_t StopMarkRst = len_t'(560);

  typedef struct packed {
    len_t hdr_mark;
    len_t hdr_space;
    len_t bit_mark;
    len_t zero_space;
    len_t one_space;
    len_t stop_mark;
  } cfg_t;

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_HDR_MARK   = 6'b000010,
    PH_HDR_SPACE  = 6'b000100,
    PH_BIT_MARK   = 6'b001000,
    PH_BIT_SPACE  = 6'b010000,
    PH_STOP_MARK  = 6'b100000
  } phase_e;

  // low bits of the byte, zero above it
  function automatic word_t load_word(logic [ByteW-1:0] data);
    word_t w;
    w = '0;
    for (int i = 0; i < int'(DataBits); i++) begin
      if (i < int'(ByteW)) begin
        w[i] = data[i % ByteW];
      end
    end
    return w;
  endfunction

endpackage

/* rtl/irpdt_in_if.sv */
// input channel of the ir transmitter: op and data byte with valid/ready
// depends on irpdt_pkg
interface irpdt_in_if
  import irpdt_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             op;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

/* rtl/irpdt_out_if.sv */
// result channel of the ir transmitter: line level and busy flag
// no dependencies
interface irpdt_out_if;
  logic valid;
  logic ready;
  logic ir_level;
  logic busy_res;

  modport source (output valid, output ir_level, output busy_res, input ready);
  modport sink   (input valid, input ir_level, input busy_res, output ready);
endinterface

/* rtl/ir_pulse_distance_transmitter.sv */
// ir pulse-distance transmitter top level: length registers and sequencer
// a result word appears in the cycle after its input word is taken
// throughput: one word per cycle unless stalled, single register stage
// the input stays ready while the result register is empty or being taken
// reset: asynchronous active low, length registers return to nec defaults
// depends on irpdt_pkg, irpdt_in_if, irpdt_out_if, irpdt_cfg, irpdt_core
module ir_pulse_distance_transmitter
  import irpdt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  len_t               cfg_data_i,
  irpdt_in_if.sink           in_i,
  irpdt_out_if.source        out_o
);

  cfg_t cfg;

  irpdt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  irpdt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

/* rtl/irpdt_cfg.sv */
// segment length registers of the ir transmitter
// depends on irpdt_pkg
module irpdt_cfg
  import irpdt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  len_t               cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_HDR_MARK:  cfg_d.hdr_mark   = cfg_data_i;
        REG_HDR_SPACE: cfg_d.hdr_space  = cfg_data_i;
        REG_BIT_MARK:  cfg_d.bit_mark   = cfg_data_i;
        REG_ZERO_SP:   cfg_d.zero_space = cfg_data_i;
        REG_ONE_SP:    cfg_d.one_space  = cfg_data_i;
        REG_STOP_MARK: cfg_d.stop_mark  = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_mark   <= HdrMarkRst;
      cfg_q.hdr_space  <= HdrSpaceRst;
      cfg_q.bit_mark   <= BitMarkRst;
      cfg_q.zero_space <= ZeroSpRst;
      cfg_q.one_space  <= OneSpRst;
      cfg_q.stop_mark  <= StopMarkRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/irpdt_core.sv */
// frame sequencer and result register of the ir transmitter
// depends on irpdt_pkg, irpdt_in_if, irpdt_out_if
module irpdt_core
  import irpdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  irpdt_in_if.sink    in_i,
  irpdt_out_if.source out_o
);

  phase_e phase_d, phase_q;
  len_t   cnt_d, cnt_q;
  word_t  shift_d, shift_q;
  bits_t  bits_d, bits_q;
  logic   vld_d, vld_q;
  logic   lvl_d, lvl_q;
  logic   busy_d, busy_q;
  logic   accept;

  assign in_i.ready = !vld_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    if (accept) begin
      if (in_i.op) begin
        if (phase_q == PH_IDLE) begin
          shift_d = load_word(in_i.data_byte);
          bits_d  = '0;
          phase_d = PH_HDR_MARK;
          cnt_d   = cfg_i.hdr_mark;
        end
      end else if (phase_q != PH_IDLE) begin
        if (cnt_q <= len_t'(1)) begin
          case (phase_q)
            PH_HDR_MARK: begin
              phase_d = PH_HDR_SPACE;
              cnt_d   = cfg_i.hdr_space;
            end
            PH_HDR_SPACE: begin
              bits_d  = bits_t'(DataBits);
              phase_d = PH_BIT_MARK;
              cnt_d   = cfg_i.bit_mark;
            end
            PH_BIT_MARK: begin
              phase_d = PH_BIT_SPACE;
              cnt_d   = shift_q[DataBits-1] ? cfg_i.one_space : cfg_i.zero_space;
            end
            PH_BIT_SPACE: begin
              shift_d = shift_q << 1;
              if (bits_q != '0) begin
                bits_d = bits_q - bits_t'(1);
              end
              if (bits_q <= bits_t'(1)) begin
                phase_d = PH_STOP_MARK;
                cnt_d   = cfg_i.stop_mark;
              end else begin
                phase_d = PH_BIT_MARK;
                cnt_d   = cfg_i.bit_mark;
              end
            end
            default: begin
              phase_d = PH_IDLE;
              cnt_d   = '0;
            end
          endcase
        end else begin
          cnt_d = cnt_q - len_t'(1);
        end
      end
    end
  end

  always_comb begin
    vld_d  = vld_q;
    lvl_d  = lvl_q;
    busy_d = busy_q;
    if (accept) begin
      vld_d  = 1'b1;
      busy_d = (phase_d != PH_IDLE);
      lvl_d  = (phase_d == PH_HDR_MARK) || (phase_d == PH_BIT_MARK) ||
               (phase_d == PH_STOP_MARK);
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      shift_q <= '0;
      bits_q  <= '0;
      vld_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      vld_q   <= vld_d;
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    lvl_q  <= lvl_d;
    busy_q <= busy_d;
  end

  assign out_o.valid    = vld_q;
  assign out_o.ir_level = lvl_q;
  assign out_o.busy_res = busy_q;

endmodule
